>>> sv/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// shared types, constants and helpers of the hall sensor angle/speed estimator
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned WEIGHT_W       = 11;
  localparam int unsigned TICK_W         = 14;
  localparam int unsigned SPEED_W        = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned MUL_B_W        = 16;
  localparam int unsigned Q_SHIFT        = 10;

  localparam logic [WEIGHT_W-1:0] NEW_WEIGHT_RST  = 11'd355;
  localparam logic [WEIGHT_W-1:0] OLD_WEIGHT_RST  = 11'd669;
  localparam logic [15:0]         ELEC_OFFSET_RST = 16'd5462;
  localparam logic [15:0]         HALF_SECTOR_RST = 16'd5462;
  localparam logic [15:0]         SPEED_SCALE_RST = 16'd7500;
  localparam logic [TICK_W-1:0]   STALL_TICKS_RST = 14'd8000;
  localparam logic [TICK_W-1:0]   TICK_MAX        = 14'd16383;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEW_WEIGHT  = 3'd0,
    CFG_OLD_WEIGHT  = 3'd1,
    CFG_ELEC_OFFSET = 3'd2,
    CFG_HALF_SECTOR = 3'd3,
    CFG_SPEED_SCALE = 3'd4,
    CFG_STALL_TICKS = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TMUL,
    ST_DSTART,
    ST_DIV,
    ST_SSTART,
    ST_SMUL,
    ST_VMUL,
    ST_INTEG,
    ST_WRAP,
    ST_ELEC,
    ST_OUT
  } state_e;

  typedef logic [2:0] sector_t;

  localparam sector_t SEC_NONE = 3'd7;

  // sector order 5,1,3,2,6,4
  function automatic sector_t sector_of(input logic [2:0] hall);
    sector_t s;
    case (hall)
      3'd5:    s = 3'd0;
      3'd1:    s = 3'd1;
      3'd3:    s = 3'd2;
      3'd2:    s = 3'd3;
      3'd6:    s = 3'd4;
      3'd4:    s = 3'd5;
      default: s = SEC_NONE;
    endcase
    return s;
  endfunction

  function automatic sector_t next_sector(input sector_t s);
    return (s == 3'd5) ? 3'd0 : s + 3'd1;
  endfunction

  function automatic sector_t prev_sector(input sector_t s);
    return (s == 3'd0) ? 3'd5 : s - 3'd1;
  endfunction

  // elaboration only
  function automatic longint sector_base(input int idx, input int abits);
    longint turn;
    turn = longint'(1) << abits;
    if (idx <= 0) begin
      return turn - 1;
    end
    return (longint'(idx) * turn + 3) / 6;
  endfunction

endpackage

>>> sv/hall_sensor_angle_speed_estimator.sv
// ----------------------------------------------------------------------------
// hall_sensor_angle_speed_estimator
// rotor angle interpolation and speed from three hall sensors
//
//   channel  direction  signals
//   in       sink       in_valid_i, in_ready_o, kind_i, hall_bits_i
//   out      source     out_valid_o, out_ready_i, electrical_angle_o,
//                       direction_o, speed_rpm_o
//   cfg      sink       cfg_we_i, cfg_idx_i, cfg_wdata_i
//
// a tick without hall change runs no multiply, a speed tick one serial multiply and a
// hall change two serial multiplies and a serial divide, the divide being skipped
// when the filtered tick count is zero
// reset loads register defaults and clears all state but the payload and scratch registers, no clearing pass
// a result stalled at the output holds the next transaction in its final state
// ----------------------------------------------------------------------------
module hall_sensor_angle_speed_estimator #(
  parameter int unsigned ANGLE_BITS = hse_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [2:0]                    hall_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ANGLE_BITS:0]           electrical_angle_o,
  output logic [1:0]                    direction_o,
  output logic [hse_pkg::SPEED_W-1:0]   speed_rpm_o,
  input  logic                          cfg_we_i,
  input  logic [hse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hse_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int unsigned AB  = ANGLE_BITS;
  localparam int unsigned EW  = AB + 1;
  localparam int unsigned RW  = ((AB > 16) ? AB : 16) + 3;
  localparam int unsigned TW  = hse_pkg::TICK_W;
  localparam int unsigned WW  = hse_pkg::WEIGHT_W;
  localparam int unsigned MB  = hse_pkg::MUL_B_W;
  localparam int unsigned MAW = (EW > TW) ? EW : TW;
  localparam int unsigned PW  = MAW + MB;
  localparam int unsigned QS  = hse_pkg::Q_SHIFT;
  localparam int unsigned SW  = PW - QS + 1;

  localparam longint TURN_L = longint'(1) << AB;
  localparam longint BASE0  = hse_pkg::sector_base(0, AB);
  localparam longint BASE1  = hse_pkg::sector_base(1, AB);
  localparam longint BASE2  = hse_pkg::sector_base(2, AB);
  localparam longint BASE3  = hse_pkg::sector_base(3, AB);
  localparam longint BASE4  = hse_pkg::sector_base(4, AB);
  localparam longint BASE5  = hse_pkg::sector_base(5, AB);

  localparam logic signed [RW-1:0] TURN = RW'(TURN_L);

  hse_pkg::state_e state_q, state_d;

  logic [WW-1:0]  nsw_q, nsw_d, ovw_q, ovw_d;
  logic [15:0]    eoff_q, eoff_d, hsa_q, hsa_d, scale_q, scale_d;
  logic [TW-1:0]  stall_q, stall_d;

  logic                  kind_q, kind_d;
  logic [2:0]            hall_q, hall_d;
  logic [2:0]            prev_hall_q, prev_hall_d;
  logic signed [RW-1:0]  rotor_q, rotor_d;
  logic [EW-1:0]         err_q, err_d;
  logic [TW-1:0]         tick_q, tick_d;
  logic [TW-1:0]         ftc_q, ftc_d;
  logic [EW-1:0]         fas_q, fas_d;
  logic [EW-1:0]         step_q, step_d;
  logic [1:0]            motion_q, motion_d;
  logic [EW-1:0]         held_q, held_d;
  logic [EW-1:0]         prev_elec_q, prev_elec_d;
  logic [15:0]           speed_q, speed_d;

  logic                  out_valid_q, out_valid_d;
  logic [EW-1:0]         out_angle_q;
  logic [1:0]            out_dir_q;
  logic [15:0]           out_speed_q;
  logic                  load;

  hse_pkg::sector_t      sec_cur, sec_prev;
  logic                  cur_ok, prev_ok, fwd, rev;
  logic signed [RW-1:0]  base_cur, fwdk, revk, raw_err, wr_err, snap;
  logic signed [RW-1:0]  wr_rot, cl_rot, el, el2;
  logic [TW-1:0]         tc_inc;
  logic [EW-1:0]         vx, vy, spd;
  logic [EW:0]           vdiff;

  logic                  mul_start, mul_done0, mul_done1, mul_done;
  logic [MAW-1:0]        mul_a0, mul_a1;
  logic [MB-1:0]         mul_b0, mul_b1;
  logic [PW-1:0]         prod0, prod1;
  logic [SW-1:0]         lpf_sum;
  logic                  div_start, div_done;
  logic [EW-1:0]         div_quo;

  // sector decode and constant tables
  always_comb begin
    sec_cur  = hse_pkg::sector_of(hall_q);
    sec_prev = hse_pkg::sector_of(prev_hall_q);
    cur_ok   = sec_cur != hse_pkg::SEC_NONE;
    prev_ok  = sec_prev != hse_pkg::SEC_NONE;
    fwd      = cur_ok && prev_ok && (sec_cur == hse_pkg::next_sector(sec_prev));
    rev      = cur_ok && prev_ok && (sec_cur == hse_pkg::prev_sector(sec_prev));
    case (sec_cur)
      3'd0: begin
        base_cur = RW'(BASE0);
        fwdk     = RW'(BASE1 + BASE0);
        revk     = RW'(BASE1 - BASE0);
      end
      3'd1: begin
        base_cur = RW'(BASE1);
        fwdk     = RW'(BASE1 + BASE1);
        revk     = RW'(BASE1 - BASE1);
      end
      3'd2: begin
        base_cur = RW'(BASE2);
        fwdk     = RW'(BASE1 + BASE2);
        revk     = RW'(BASE1 - BASE2);
      end
      3'd3: begin
        base_cur = RW'(BASE3);
        fwdk     = RW'(BASE1 + BASE3);
        revk     = RW'(BASE1 - BASE3);
      end
      3'd4: begin
        base_cur = RW'(BASE4);
        fwdk     = RW'(BASE1 + BASE4);
        revk     = RW'(BASE1 - BASE4);
      end
      3'd5: begin
        base_cur = RW'(BASE5);
        fwdk     = RW'(BASE1 + BASE5);
        revk     = RW'(BASE1 - BASE5);
      end
      default: begin
        base_cur = '0;
        fwdk     = '0;
        revk     = '0;
      end
    endcase
  end

  // angle error, stall snap, tick count
  always_comb begin
    raw_err = fwd ? (fwdk - rotor_q) : (revk + rotor_q);
    if (raw_err > TURN) begin
      wr_err = raw_err - TURN;
    end else if (raw_err[RW-1]) begin
      wr_err = raw_err + TURN;
    end else begin
      wr_err = raw_err;
    end
    snap   = base_cur + RW'(hsa_q);
    tc_inc = (tick_q == hse_pkg::TICK_MAX) ? tick_q : tick_q + TW'(1);
  end

  // angle change since the last speed tick, wrapped to one turn
  always_comb begin
    vx    = (motion_q == hse_pkg::DIR_REV) ? prev_elec_q : held_q;
    vy    = (motion_q == hse_pkg::DIR_REV) ? held_q : prev_elec_q;
    vdiff = {1'b0, vx} - {1'b0, vy};
    if (motion_q != hse_pkg::DIR_FWD && motion_q != hse_pkg::DIR_REV) begin
      spd = '0;
    end else if (vdiff[EW]) begin
      spd = {1'b0, vdiff[AB-1:0]};
    end else begin
      spd = vdiff[EW-1:0];
    end
  end

  // rotor wrap and clamp, electrical angle
  always_comb begin
    if (rotor_q > TURN) begin
      wr_rot = rotor_q - TURN;
    end else if (rotor_q[RW-1]) begin
      wr_rot = rotor_q + TURN;
    end else begin
      wr_rot = rotor_q;
    end
    if (wr_rot > TURN) begin
      cl_rot = TURN;
    end else if (wr_rot[RW-1]) begin
      cl_rot = '0;
    end else begin
      cl_rot = wr_rot;
    end
    el  = rotor_q - RW'(eoff_q);
    el2 = el[RW-1] ? (el + TURN) : el;
  end

  // multiplier operands
  always_comb begin
    if (state_q == hse_pkg::ST_SSTART) begin
      mul_a0 = MAW'(fas_q);
      mul_b0 = MB'(ovw_q);
      mul_a1 = MAW'(step_q);
      mul_b1 = MB'(nsw_q);
    end else if (kind_q) begin
      mul_a0 = MAW'(spd);
      mul_b0 = scale_q;
      mul_a1 = '0;
      mul_b1 = '0;
    end else begin
      mul_a0 = MAW'(ftc_q);
      mul_b0 = MB'(ovw_q);
      mul_a1 = MAW'(tick_q);
      mul_b1 = MB'(nsw_q);
    end
  end

  assign mul_done = mul_done0 & mul_done1;
  assign lpf_sum  = SW'(prod0[PW-1:QS]) + SW'(prod1[PW-1:QS]);

  hse_mul #(
    .AW (MAW),
    .BW (MB)
  ) u_mul0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a0),
    .b_i     (mul_b0),
    .done_o  (mul_done0),
    .prod_o  (prod0)
  );

  hse_mul #(
    .AW (MAW),
    .BW (MB)
  ) u_mul1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a1),
    .b_i     (mul_b1),
    .done_o  (mul_done1),
    .prod_o  (prod1)
  );

  hse_div #(
    .NW (EW),
    .DW (TW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (err_q),
    .den_i   (ftc_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    hall_d      = hall_q;
    prev_hall_d = prev_hall_q;
    rotor_d     = rotor_q;
    err_d       = err_q;
    tick_d      = tick_q;
    ftc_d       = ftc_q;
    fas_d       = fas_q;
    step_d      = step_q;
    motion_d    = motion_q;
    held_d      = held_q;
    prev_elec_d = prev_elec_q;
    speed_d     = speed_q;
    in_ready_o  = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    load        = 1'b0;
    case (state_q)
      hse_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d  = kind_i;
          hall_d  = hall_bits_i;
          state_d = hse_pkg::ST_DECODE;
        end
      end
      hse_pkg::ST_DECODE: begin
        if (kind_q) begin
          mul_start = 1'b1;
          state_d   = hse_pkg::ST_VMUL;
        end else if (hall_q != prev_hall_q) begin
          if (fwd) begin
            err_d    = wr_err[EW-1:0];
            motion_d = hse_pkg::DIR_FWD;
          end else if (rev) begin
            err_d    = wr_err[EW-1:0];
            motion_d = hse_pkg::DIR_REV;
          end else begin
            motion_d = hse_pkg::DIR_STOP;
          end
          tick_d    = '0;
          mul_start = 1'b1;
          state_d   = hse_pkg::ST_TMUL;
        end else begin
          tick_d = tc_inc;
          if (tc_inc >= stall_q) begin
            tick_d   = '0;
            speed_d  = '0;
            fas_d    = '0;
            motion_d = hse_pkg::DIR_STOP;
            if (cur_ok) begin
              rotor_d = snap;
            end
          end
          state_d = hse_pkg::ST_INTEG;
        end
      end
      hse_pkg::ST_TMUL: begin
        if (mul_done) begin
          ftc_d   = (|lpf_sum[SW-1:TW]) ? hse_pkg::TICK_MAX : lpf_sum[TW-1:0];
          state_d = hse_pkg::ST_DSTART;
        end
      end
      hse_pkg::ST_DSTART: begin
        if (ftc_q == '0) begin
          step_d  = '0;
          state_d = hse_pkg::ST_SSTART;
        end else begin
          div_start = 1'b1;
          state_d   = hse_pkg::ST_DIV;
        end
      end
      hse_pkg::ST_DIV: begin
        if (div_done) begin
          step_d  = div_quo;
          state_d = hse_pkg::ST_SSTART;
        end
      end
      hse_pkg::ST_SSTART: begin
        mul_start = 1'b1;
        state_d   = hse_pkg::ST_SMUL;
      end
      hse_pkg::ST_SMUL: begin
        if (mul_done) begin
          fas_d   = (|lpf_sum[SW-1:EW]) ? '1 : lpf_sum[EW-1:0];
          state_d = hse_pkg::ST_INTEG;
        end
      end
      hse_pkg::ST_VMUL: begin
        if (mul_done) begin
          speed_d     = prod0[AB+15:AB];
          prev_elec_d = held_q;
          state_d     = hse_pkg::ST_OUT;
        end
      end
      hse_pkg::ST_INTEG: begin
        if (motion_q == hse_pkg::DIR_FWD) begin
          rotor_d = rotor_q + RW'(fas_q);
        end else if (motion_q == hse_pkg::DIR_REV) begin
          rotor_d = rotor_q - RW'(fas_q);
        end
        state_d = hse_pkg::ST_WRAP;
      end
      hse_pkg::ST_WRAP: begin
        rotor_d = cl_rot;
        state_d = hse_pkg::ST_ELEC;
      end
      hse_pkg::ST_ELEC: begin
        held_d      = el2[RW-1] ? '0 : el2[EW-1:0];
        prev_hall_d = hall_q;
        state_d     = hse_pkg::ST_OUT;
      end
      hse_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = hse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = hse_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & ~out_ready_i);

  // configuration writes
  always_comb begin
    nsw_d   = nsw_q;
    ovw_d   = ovw_q;
    eoff_d  = eoff_q;
    hsa_d   = hsa_q;
    scale_d = scale_q;
    stall_d = stall_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        hse_pkg::CFG_NEW_WEIGHT:  nsw_d   = cfg_wdata_i[WW-1:0];
        hse_pkg::CFG_OLD_WEIGHT:  ovw_d   = cfg_wdata_i[WW-1:0];
        hse_pkg::CFG_ELEC_OFFSET: eoff_d  = cfg_wdata_i;
        hse_pkg::CFG_HALF_SECTOR: hsa_d   = cfg_wdata_i;
        hse_pkg::CFG_SPEED_SCALE: scale_d = cfg_wdata_i;
        hse_pkg::CFG_STALL_TICKS: stall_d = cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hse_pkg::ST_IDLE;
      nsw_q       <= hse_pkg::NEW_WEIGHT_RST;
      ovw_q       <= hse_pkg::OLD_WEIGHT_RST;
      eoff_q      <= hse_pkg::ELEC_OFFSET_RST;
      hsa_q       <= hse_pkg::HALF_SECTOR_RST;
      scale_q     <= hse_pkg::SPEED_SCALE_RST;
      stall_q     <= hse_pkg::STALL_TICKS_RST;
      prev_hall_q <= '0;
      rotor_q     <= '0;
      err_q       <= '0;
      tick_q      <= '0;
      ftc_q       <= '0;
      fas_q       <= '0;
      motion_q    <= hse_pkg::DIR_STOP;
      held_q      <= '0;
      prev_elec_q <= '0;
      speed_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nsw_q       <= nsw_d;
      ovw_q       <= ovw_d;
      eoff_q      <= eoff_d;
      hsa_q       <= hsa_d;
      scale_q     <= scale_d;
      stall_q     <= stall_d;
      prev_hall_q <= prev_hall_d;
      rotor_q     <= rotor_d;
      err_q       <= err_d;
      tick_q      <= tick_d;
      ftc_q       <= ftc_d;
      fas_q       <= fas_d;
      motion_q    <= motion_d;
      held_q      <= held_d;
      prev_elec_q <= prev_elec_d;
      speed_q     <= speed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // transaction payload and scratch registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    hall_q <= hall_d;
    step_q <= step_d;
    if (load) begin
      out_angle_q <= held_q;
      out_dir_q   <= motion_q;
      out_speed_q <= speed_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign electrical_angle_o = out_angle_q;
  assign direction_o        = out_dir_q;
  assign speed_rpm_o        = out_speed_q;

endmodule

>>> sv/hse_mul.sv
// ----------------------------------------------------------------------------
// hse_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module hse_mul #(
  parameter int unsigned AW = hse_pkg::TICK_W,
  parameter int unsigned BW = hse_pkg::MUL_B_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] p_q, p_d;
  logic [AW-1:0]    a_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW:0]      sum;

  assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    p_d    = p_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d    = {{AW{1'b0}}, b_i};
      cnt_d  = CW'(BW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {sum, p_q[BW-1:1]};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (start_i) begin
      a_q <= a_i;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

>>> sv/hse_div.sv
// ----------------------------------------------------------------------------
// hse_div
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hse_div #(
  parameter int unsigned NW = hse_pkg::ANGLE_BITS_DEF + 1,
  parameter int unsigned DW = hse_pkg::TICK_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> tb/sv/hse_result_checker.sv
// ----------------------------------------------------------------------------
// hse_result_checker
// watches the tick and result channels of the hall sensor estimator, keeps
// its own model of the angle and speed state and checks every result
// ----------------------------------------------------------------------------
module hse_result_checker #(
  parameter int unsigned ANGLE_BITS = hse_pkg::ANGLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          kind_i,
  input  logic [2:0]                    hall_bits_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [ANGLE_BITS:0]           electrical_angle_i,
  input  logic [1:0]                    direction_i,
  input  logic [hse_pkg::SPEED_W-1:0]   speed_rpm_i,
  input  logic                          cfg_we_i,
  input  logic [hse_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hse_pkg::CFG_W-1:0]     cfg_wdata_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            items_o,
  output int                            speed_ticks_o,
  output int                            stalls_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam int     ELEC_W   = ANGLE_BITS + 1;
  localparam int     ERR_W    = ANGLE_BITS + 2;
  localparam longint TURN     = longint'(1) << ANGLE_BITS;
  localparam longint STEP_CAP = 2 * TURN - 1;

  typedef struct packed {
    logic [ELEC_W-1:0]  angle;
    dir_e               dir;
    logic [SPEED_W-1:0] rpm;
  } reading_t;

  reading_t expected_readings [$];

  // register copies
  logic [WEIGHT_W-1:0] w_new, w_old;
  logic [15:0]         offs, half, scale;
  logic [TICK_W-1:0]   stall_lim;

  // estimator state
  logic [2:0]          last_hall;
  logic [ERR_W-1:0]    rotor;
  logic [ERR_W-1:0]    sect_err;
  logic [TICK_W-1:0]   ticks;
  logic [TICK_W-1:0]   ticks_lp;
  logic [ELEC_W-1:0]   step_lp;
  dir_e                motion;
  logic [ELEC_W-1:0]   elec;
  logic [ELEC_W-1:0]   elec_ref;
  logic [SPEED_W-1:0]  rpm;

  function automatic int hall_sector(input logic [2:0] hall);
    case (hall)
      3'd5:    return 0;
      3'd1:    return 1;
      3'd3:    return 2;
      3'd2:    return 3;
      3'd6:    return 4;
      3'd4:    return 5;
      default: return -1;
    endcase
  endfunction

  function automatic longint sector_angle(input int s);
    if (s <= 0) begin
      return TURN - 1;
    end
    return (longint'(s) * TURN + 3) / 6;
  endfunction

  function automatic longint wrap_turn(input longint a);
    if (a > TURN) begin
      return a - TURN;
    end
    if (a < 0) begin
      return a + TURN;
    end
    return a;
  endfunction

  // q10 first order low-pass with saturation
  function automatic longint blend(input longint prev, input longint fresh, input longint cap);
    longint v;
    v = ((longint'(w_old) * prev) >>> Q_SHIFT) + ((longint'(w_new) * fresh) >>> Q_SHIFT);
    return (v > cap) ? cap : v;
  endfunction

  function automatic void clear_state();
    w_new     = NEW_WEIGHT_RST;
    w_old     = OLD_WEIGHT_RST;
    offs      = ELEC_OFFSET_RST;
    half      = HALF_SECTOR_RST;
    scale     = SPEED_SCALE_RST;
    stall_lim = STALL_TICKS_RST;
    last_hall = '0;
    rotor     = '0;
    sect_err  = '0;
    ticks     = '0;
    ticks_lp  = '0;
    step_lp   = '0;
    motion    = DIR_STOP;
    elec      = '0;
    elec_ref  = '0;
    rpm       = '0;
  endfunction

  function automatic reading_t estimate_reading(input logic is_speed, input logic [2:0] hall);
    reading_t r;
    int       s;
    int       p;
    longint   rot;
    longint   q;
    longint   d;
    longint   e;
    if (is_speed) begin
      d = 0;
      if (motion == DIR_FWD) begin
        d = longint'(elec) - longint'(elec_ref);
      end else if (motion == DIR_REV) begin
        d = longint'(elec_ref) - longint'(elec);
      end
      if (d < 0) begin
        d += TURN;
      end
      rpm = SPEED_W'((d * longint'(scale)) >>> ANGLE_BITS);
      elec_ref = elec;
      speed_ticks_o++;
    end else begin
      s = hall_sector(hall);
      if (hall != last_hall) begin
        p = hall_sector(last_hall);
        rot = longint'(rotor);
        if (s >= 0 && p >= 0 && s == (p + 1) % 6) begin
          sect_err = ERR_W'(wrap_turn(sector_angle(1) + sector_angle(s) - rot));
          motion = DIR_FWD;
        end else if (s >= 0 && p >= 0 && s == (p + 5) % 6) begin
          sect_err = ERR_W'(wrap_turn(sector_angle(1) + rot - sector_angle(s)));
          motion = DIR_REV;
        end else begin
          motion = DIR_STOP;
        end
        ticks_lp = TICK_W'(blend(ticks_lp, ticks, TICK_MAX));
        q = 0;
        if (ticks_lp != 0) begin
          q = longint'(sect_err) / longint'(ticks_lp);
        end
        step_lp = ELEC_W'(blend(step_lp, q, STEP_CAP));
        ticks = '0;
      end else begin
        if (ticks < TICK_MAX) begin
          ticks++;
        end
        if (ticks >= stall_lim) begin
          ticks   = '0;
          rpm     = '0;
          step_lp = '0;
          motion  = DIR_STOP;
          if (s >= 0) begin
            rotor = ERR_W'(sector_angle(s) + longint'(half));
          end
          stalls_o++;
        end
      end
      rot = longint'(rotor);
      if (motion == DIR_FWD) begin
        rot += longint'(step_lp);
      end else if (motion == DIR_REV) begin
        rot -= longint'(step_lp);
      end
      rot = wrap_turn(rot);
      if (rot > TURN) begin
        rot = TURN;
      end
      if (rot < 0) begin
        rot = 0;
      end
      rotor = ERR_W'(rot);
      e = wrap_turn(rot - longint'(offs));
      if (e < 0) begin
        e = 0;
      end
      elec = ELEC_W'(e);
      last_hall = hall;
    end
    r.angle = elec;
    r.dir   = motion;
    r.rpm   = rpm;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      clear_state();
      expected_readings.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      items_o       = 0;
      speed_ticks_o = 0;
      stalls_o      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NEW_WEIGHT:  w_new     = cfg_wdata_i[WEIGHT_W-1:0];
          CFG_OLD_WEIGHT:  w_old     = cfg_wdata_i[WEIGHT_W-1:0];
          CFG_ELEC_OFFSET: offs      = cfg_wdata_i[15:0];
          CFG_HALF_SECTOR: half      = cfg_wdata_i[15:0];
          CFG_SPEED_SCALE: scale     = cfg_wdata_i[15:0];
          CFG_STALL_TICKS: stall_lim = cfg_wdata_i[TICK_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_readings.push_back(estimate_reading(kind_i, hall_bits_i));
        items_o++;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) begin
            $display("%0t: result with no transaction outstanding: angle %0d dir %0d rpm %0d",
                     $realtime, electrical_angle_i, direction_i, speed_rpm_i);
          end
        end else begin
          want = expected_readings.pop_front();
          if (electrical_angle_i !== want.angle || direction_i !== want.dir ||
              speed_rpm_i !== want.rpm) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch: expected angle %0d dir %0d rpm %0d, got angle %0d dir %0d rpm %0d",
                       $realtime, want.angle, want.dir, want.rpm,
                       electrical_angle_i, direction_i, speed_rpm_i);
            end
          end
        end
      end
      pending_o = expected_readings.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// regression for the hall sensor angle/speed estimator: directed hall
// sequences, then phases of random rotation, noise and stalls under several
// register settings, with random idling on both channels
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hse_pkg::*;

  localparam int N_REGS        = 6;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 175;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 80;
  localparam int LONG_HOLD     = 60;

  localparam logic [2:0] HALL_ALL_LOW  = 3'd0;
  localparam logic [2:0] HALL_ALL_HIGH = 3'd7;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     kind      = 1'b0;
  logic [2:0]               hall      = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [ANGLE_BITS_DEF:0]  angle;
  logic [1:0]               dir;
  logic [SPEED_W-1:0]       rpm;
  logic                     cfg_we    = 1'b0;
  cfg_idx_e                 cfg_idx   = CFG_NEW_WEIGHT;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  int fails;
  int pending;
  int items_seen;
  int speed_seen;
  int stalls_seen;

  int         burst_left    = 0;
  bit         steady        = 1'b0;
  bit         fwd           = 1'b1;
  int         cur_sec       = 0;
  int         phase_sent    = 0;
  int         settings_used = 0;
  int         idle_cycles   = 0;
  logic [CFG_W-1:0] reg_plan [N_REGS];

  hall_sensor_angle_speed_estimator dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .kind_i             (kind),
    .hall_bits_i        (hall),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .electrical_angle_o (angle),
    .direction_o        (dir),
    .speed_rpm_o        (rpm),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata)
  );

  hse_result_checker #(
    .ANGLE_BITS (ANGLE_BITS_DEF)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .kind_i             (kind),
    .hall_bits_i        (hall),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .electrical_angle_i (angle),
    .direction_i        (dir),
    .speed_rpm_i        (rpm),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .fail_count_o       (fails),
    .pending_o          (pending),
    .items_o            (items_seen),
    .speed_ticks_o      (speed_seen),
    .stalls_o           (stalls_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transaction for %0d cycles, giving up", IDLE_LIMIT);
      $display("hall_sensor_angle_speed_estimator regression: fail");
      $finish;
    end
  end

  // result side: segments of different stall patterns plus occasional long hold-offs
  initial begin : receiver
    int       cyc;
    int       seg_left;
    int       hold_left;
    int       next_hold;
    int       period;
    int       duty;
    rx_mode_e mode;
    logic     go;
    cyc       = 0;
    seg_left  = 0;
    hold_left = 0;
    next_hold = $urandom_range(2000, 6000);
    period    = 4;
    duty      = 2;
    mode      = RX_OPEN;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == next_hold) begin
        hold_left = $urandom_range(300, 600);
        next_hold = cyc + $urandom_range(20000, 60000);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(50, 400);
        period   = $urandom_range(2, 9);
        duty     = $urandom_range(1, period - 1);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        go = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   go = 1'b1;
          RX_COIN:   go = 1'($urandom_range(0, 1));
          RX_SPARSE: go = ($urandom_range(0, 4) == 0);
          default:   go = ((cyc % period) < duty);
        endcase
      end
      out_ready <= go;
    end
  end

  function automatic logic [2:0] hall_code(input int s);
    case (s)
      0:       return 3'd5;
      1:       return 3'd1;
      2:       return 3'd3;
      3:       return 3'd2;
      4:       return 3'd6;
      default: return 3'd4;
    endcase
  endfunction

  task automatic offer(input logic k, input logic [2:0] h);
    int gap;
    in_valid <= 1'b1;
    kind     <= k;
    hall     <= h;
    do @(posedge clk); while (!in_ready);
    phase_sent++;
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_plan();
    for (int i = 0; i < N_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= cfg_idx_e'(i);
      cfg_wdata <= reg_plan[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic hold_ticks(input int n, input logic [2:0] code, input bit mix_speed);
    repeat (n) begin
      if (mix_speed && $urandom_range(0, 5) == 0) begin
        offer(1'b1, 3'($urandom_range(0, 7)));
      end else begin
        offer(1'b0, code);
      end
    end
  endtask

  task automatic spin(input int n, input bit forward, input int dwell_max);
    repeat (n) begin
      cur_sec = forward ? (cur_sec + 1) % 6 : (cur_sec + 5) % 6;
      offer(1'b0, hall_code(cur_sec));
      hold_ticks($urandom_range(0, dwell_max), hall_code(cur_sec), 1'b1);
    end
  endtask

  function automatic void pick_plan(input int p);
    int w;
    case (p)
      0: begin
        reg_plan[CFG_NEW_WEIGHT]  = '0;
        reg_plan[CFG_OLD_WEIGHT]  = '0;
        reg_plan[CFG_ELEC_OFFSET] = '0;
        reg_plan[CFG_HALF_SECTOR] = '0;
        reg_plan[CFG_SPEED_SCALE] = '0;
        reg_plan[CFG_STALL_TICKS] = 16'd1;
      end
      1: begin
        reg_plan[CFG_NEW_WEIGHT]  = 16'd1024;
        reg_plan[CFG_OLD_WEIGHT]  = 16'd1024;
        reg_plan[CFG_ELEC_OFFSET] = 16'hFFFF;
        reg_plan[CFG_HALF_SECTOR] = 16'hFFFF;
        reg_plan[CFG_SPEED_SCALE] = 16'hFFFF;
        reg_plan[CFG_STALL_TICKS] = 16'($urandom_range(8, 40));
      end
      default: begin
        w = $urandom_range(0, 1024);
        reg_plan[CFG_NEW_WEIGHT]  = 16'(w);
        reg_plan[CFG_OLD_WEIGHT]  = ($urandom_range(0, 2) != 0) ? 16'(1024 - w)
                                                                : 16'($urandom_range(0, 1024));
        reg_plan[CFG_ELEC_OFFSET] = 16'($urandom_range(0, 65535));
        reg_plan[CFG_HALF_SECTOR] = 16'($urandom_range(0, 65535));
        reg_plan[CFG_SPEED_SCALE] = 16'($urandom_range(0, 65535));
        reg_plan[CFG_STALL_TICKS] = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 2))
                                                                : 16'($urandom_range(3, 120));
      end
    endcase
  endfunction

  task automatic random_phase();
    int         lim;
    int         pick;
    int         dmax;
    logic [2:0] code;
    lim = int'(reg_plan[CFG_STALL_TICKS]);
    phase_sent = 0;
    while (phase_sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 4) == 0) begin
          fwd = !fwd;
        end
        if ($urandom_range(0, 5) == 0) begin
          dmax = lim + 2;
          spin($urandom_range(1, 3), fwd, dmax);
        end else begin
          dmax = $urandom_range(0, 12);
          spin($urandom_range(1, 12), fwd, dmax);
        end
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 4)) offer(1'b0, 3'($urandom_range(0, 7)));
      end else if (pick < 88) begin
        code = $urandom_range(0, 1) ? HALL_ALL_HIGH : HALL_ALL_LOW;
        offer(1'b0, code);
        hold_ticks($urandom_range(0, lim + 2), code, 1'b1);
      end else if (pick < 95) begin
        // skip over one or more sectors
        cur_sec = (cur_sec + $urandom_range(2, 4)) % 6;
        offer(1'b0, hall_code(cur_sec));
      end else begin
        repeat ($urandom_range(1, 5)) offer(1'b1, 3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults with a short stall time
    reg_plan[CFG_NEW_WEIGHT]  = CFG_W'(NEW_WEIGHT_RST);
    reg_plan[CFG_OLD_WEIGHT]  = CFG_W'(OLD_WEIGHT_RST);
    reg_plan[CFG_ELEC_OFFSET] = CFG_W'(ELEC_OFFSET_RST);
    reg_plan[CFG_HALF_SECTOR] = CFG_W'(HALF_SECTOR_RST);
    reg_plan[CFG_SPEED_SCALE] = CFG_W'(SPEED_SCALE_RST);
    reg_plan[CFG_STALL_TICKS] = 16'd4;
    load_plan();
    offer(1'b1, HALL_ALL_HIGH);
    offer(1'b0, HALL_ALL_LOW);
    offer(1'b0, HALL_ALL_HIGH);
    offer(1'b0, 3'd5);
    cur_sec = 0;
    spin(6, 1'b1, 0);
    offer(1'b1, HALL_ALL_LOW);
    spin(5, 1'b0, 0);
    // jump from sector one to sector three, then a stall on a valid code
    offer(1'b0, 3'd2);
    offer(1'b1, 3'd5);
    hold_ticks(4, 3'd2, 1'b0);
    // stall while the code is invalid
    offer(1'b0, HALL_ALL_LOW);
    hold_ticks(4, HALL_ALL_LOW, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      pick_plan(p);
      load_plan();
      steady = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 24);
      random_phase();
      drain();
    end

    // long stall time, reached once by holding one code
    pick_plan(RANDOM_PHASES);
    reg_plan[CFG_STALL_TICKS] = CFG_W'(LONG_HOLD - 4);
    load_plan();
    steady = 1'b1;
    spin(3, 1'b1, 5);
    hold_ticks(LONG_HOLD, hall_code(cur_sec), 1'b0);
    spin(2, 1'b1, 3);
    drain();

    $display("covered %0d input transactions, %0d of them speed ticks, with %0d stalls",
             items_seen, speed_seen, stalls_seen);
    $display("over %0d register settings with random idling on both channels", settings_used);
    if (fails == 0 && pending == 0) begin
      $display("hall_sensor_angle_speed_estimator regression: pass");
    end else begin
      $display("%0d failures", fails);
      $display("hall_sensor_angle_speed_estimator regression: fail");
    end
    $finish;
  end

endmodule
